// ===== hdl/dts_pkg.sv =====
`default_nettype none
package dts_pkg;

   localparam int MAX_TILES  = 1024;
   localparam int MAX_DIM    = 4096;
   localparam int MAP_WORD_W = 64;
   localparam int MAP_BIT_W  = $clog2(MAP_WORD_W);
   localparam int MAP_WORDS  = (MAX_TILES + MAP_WORD_W - 1) / MAP_WORD_W;
   localparam int MAP_AW     = $clog2(MAP_WORDS);

   localparam int TILE_CAP   = 32;
   localparam int ROWCOL_W   = $clog2(TILE_CAP);
   localparam int TILE_IDX_W = $clog2(TILE_CAP * TILE_CAP);

   localparam int DIM_W      = 13;
   localparam int CNT_W      = 6;
   localparam int POS_W      = 12;
   localparam int COORD_W    = ROWCOL_W + DIM_W;
   localparam int ADDR_W     = 24;
   localparam int PIX_W      = 32;
   localparam int KIND_W     = 2;
   localparam int IDX_W      = 4;

   localparam int Q_DEPTH    = 4;
   localparam int Q_AW       = $clog2(Q_DEPTH);

   localparam int DIV_STEPS  = DIM_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = DIM_W;

   localparam logic [KIND_W-1:0] KIND_START = 2'd0;
   localparam logic [KIND_W-1:0] KIND_MAP   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_ACROSS = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TILES_DOWN   = 2'd3;

   localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd1024;
   localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd1024;
   localparam logic [CNT_W-1:0] TILES_ACROSS_RST = 6'd16;
   localparam logic [CNT_W-1:0] TILES_DOWN_RST   = 6'd16;

   typedef enum logic [1:0] {
      OP_START,
      OP_MAP,
      OP_PIXEL
   } dts_op_kind_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_DIV_W,
      B_DIV_H,
      B_SEEK,
      B_TEST,
      B_XY,
      B_EMIT
   } dts_back_state_type;

   typedef struct packed {
      logic [KIND_W-1:0]     kind;
      logic [IDX_W-1:0]      map_index;
      logic [MAP_WORD_W-1:0] map_word;
      logic [PIX_W-1:0]      pixel;
   } dts_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] address;
      logic [PIX_W-1:0]  pixel_out;
      logic              last;
      logic              dropped;
   } dts_rsp_type;

   typedef struct packed {
      dts_op_kind_type       op;
      logic [IDX_W-1:0]      index;
      logic [MAP_WORD_W-1:0] data;
   } dts_op_type;

   // frame sizes and tile counts, already clamped
   typedef struct packed {
      logic [DIM_W-1:0] fw;
      logic [DIM_W-1:0] fh;
      logic [CNT_W-1:0] across;
      logic [CNT_W-1:0] down;
   } dts_cfg_type;

   function automatic logic [DIM_W-1:0] cap_dim(input logic [DIM_W-1:0] v);
      if (32'(v) > MAX_DIM) begin
         return DIM_W'(MAX_DIM);
      end
      return v;
   endfunction

   function automatic logic [CNT_W-1:0] cap_count(input logic [CNT_W-1:0] v);
      if (32'(v) > TILE_CAP) begin
         return CNT_W'(TILE_CAP);
      end
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== hdl/dirty_tile_scatter.sv =====
`default_nettype none
// channel   ports                                   transfer when
// req       req_valid  req_ready  req_data          req_valid && req_ready
// rsp       rsp_valid  rsp_ready  rsp_data          rsp_valid && rsp_ready
// csr       csr_valid  csr_ready  csr_index csr_data csr_valid && csr_ready (always ready)
//
// Pixel in a located tile: placed in IDLE, sent from EMIT (a tile's last seeks first).
// Tile search: each tile probed takes a registered map RAM read (SEEK), then a bit test (TEST);
// a tile-row wrap takes a SEEK step; start takes two 13-step divisions;
// a map load is written to the map RAM from IDLE. A 4-entry queue sits between front and back.
// Synchronous active-high reset; the map RAM is not cleared.
// rsp backpressure stalls only the back; the front keeps filling the queue.
module dirty_tile_scatter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire dts_pkg::dts_req_type                req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output dts_pkg::dts_rsp_type                     rsp_data,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [dts_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [dts_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic [dts_pkg::DIM_W-1:0] frame_width_ff, frame_width_in;
   logic [dts_pkg::DIM_W-1:0] frame_height_ff, frame_height_in;
   logic [dts_pkg::CNT_W-1:0] tiles_across_ff, tiles_across_in;
   logic [dts_pkg::CNT_W-1:0] tiles_down_ff, tiles_down_in;
   logic                      csr_wr;
   dts_pkg::dts_cfg_type      cfg;

   logic                      push_valid;
   logic                      push_ready;
   dts_pkg::dts_op_type       push_op;
   logic                      head_valid;
   logic                      head_pop;
   dts_pkg::dts_op_type       head;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      tiles_across_in = tiles_across_ff;
      tiles_down_in   = tiles_down_ff;
      if (csr_wr) begin
         unique case (csr_index)
            dts_pkg::CSR_FRAME_WIDTH:  frame_width_in  = csr_data;
            dts_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_data;
            dts_pkg::CSR_TILES_ACROSS: tiles_across_in = csr_data[dts_pkg::CNT_W-1:0];
            dts_pkg::CSR_TILES_DOWN:   tiles_down_in   = csr_data[dts_pkg::CNT_W-1:0];
            default:                   frame_width_in  = frame_width_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= dts_pkg::FRAME_WIDTH_RST;
         frame_height_ff <= dts_pkg::FRAME_HEIGHT_RST;
         tiles_across_ff <= dts_pkg::TILES_ACROSS_RST;
         tiles_down_ff   <= dts_pkg::TILES_DOWN_RST;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         tiles_across_ff <= tiles_across_in;
         tiles_down_ff   <= tiles_down_in;
      end
   end

   assign cfg.fw     = dts_pkg::cap_dim(frame_width_ff);
   assign cfg.fh     = dts_pkg::cap_dim(frame_height_ff);
   assign cfg.across = dts_pkg::cap_count(tiles_across_ff);
   assign cfg.down   = dts_pkg::cap_count(tiles_down_ff);

   dts_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op)
   );

   dts_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_op    (push_op),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_op     (head)
   );

   dts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cfg_wr     (csr_wr),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head       (head),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_last_not_dropped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.last && rsp_data.dropped))
      else $error("result flagged both last and dropped");

   a_dropped_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dropped) |-> rsp_data.address == '0)
      else $error("dropped pixel carries a nonzero address");

   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== hdl/dts_ram.sv =====
`default_nettype none
module dts_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== hdl/dts_div.sv =====
`default_nettype none
module dts_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       go,
   input  wire logic [dts_pkg::DIM_W-1:0]  dividend,
   input  wire logic [dts_pkg::CNT_W-1:0]  divisor,
   output logic                            done,
   output logic      [dts_pkg::DIM_W-1:0]  quotient
);

   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           zero_ff, zero_in;
   logic [dts_pkg::DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [dts_pkg::CNT_W-1:0]      rem_ff, rem_in;
   logic [dts_pkg::CNT_W-1:0]      dvs_ff, dvs_in;
   logic [dts_pkg::DIM_W-1:0]      quo_ff, quo_in;
   logic [dts_pkg::CNT_W:0]        trial;
   logic                           fits;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[dts_pkg::DIM_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (go) begin
         busy_in = 1'b1;
         zero_in = divisor == '0;
         cnt_in  = dts_pkg::DIV_CNT_W'(dts_pkg::DIV_STEPS - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? dts_pkg::CNT_W'(trial - {1'b0, dvs_ff})
                       : dts_pkg::CNT_W'(trial);
         quo_in = {quo_ff[dts_pkg::DIM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      zero_ff <= zero_in;
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      dvs_ff  <= dvs_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = zero_ff ? '0 : quo_ff;

endmodule
`default_nettype wire

// ===== hdl/dts_fifo.sv =====
`default_nettype none
module dts_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_ready,
   input  wire dts_pkg::dts_op_type push_op,
   output logic                     pop_valid,
   input  wire logic                pop_ready,
   output dts_pkg::dts_op_type      pop_op
);

   dts_pkg::dts_op_type          q_ff [dts_pkg::Q_DEPTH];
   logic [dts_pkg::Q_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [dts_pkg::Q_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [dts_pkg::Q_AW:0]       count_ff, count_in;
   logic                         do_push;
   logic                         do_pop;

   assign push_ready = 32'(count_ff) < dts_pkg::Q_DEPTH;
   assign pop_valid  = count_ff != '0;
   assign pop_op     = q_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         q_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/dts_front.sv =====
`default_nettype none
module dts_front (
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire dts_pkg::dts_req_type req_data,
   output logic                      push_valid,
   input  wire logic                 push_ready,
   output dts_pkg::dts_op_type       push_op
);

   logic keep;

   // unused kinds and map words beyond the bitmap are taken and discarded here
   always_comb begin
      push_op.index = req_data.map_index;
      push_op.data  = req_data.map_word;
      push_op.op    = dts_pkg::OP_PIXEL;
      keep          = 1'b0;
      unique case (req_data.kind)
         dts_pkg::KIND_START: begin
            push_op.op = dts_pkg::OP_START;
            keep       = 1'b1;
         end
         dts_pkg::KIND_MAP: begin
            push_op.op = dts_pkg::OP_MAP;
            keep       = 32'(req_data.map_index) < dts_pkg::MAP_WORDS;
         end
         dts_pkg::KIND_PIXEL: begin
            push_op.op   = dts_pkg::OP_PIXEL;
            push_op.data = dts_pkg::MAP_WORD_W'(req_data.pixel);
            keep         = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_ready  = push_ready;
   assign push_valid = req_valid && keep;

endmodule
`default_nettype wire

// ===== hdl/dts_back.sv =====
`default_nettype none
module dts_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire dts_pkg::dts_cfg_type cfg,
   input  wire logic                 cfg_wr,
   input  wire logic                 head_valid,
   output logic                      head_pop,
   input  wire dts_pkg::dts_op_type  head,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output dts_pkg::dts_rsp_type      rsp_data
);

   localparam int SUM_W  = dts_pkg::TILE_IDX_W + 1;
   localparam int PROD_W = dts_pkg::COORD_W + dts_pkg::DIM_W;

   dts_pkg::dts_back_state_type state_ff, state_in;

   logic [dts_pkg::CNT_W-1:0]   tcol_ff, tcol_in;
   logic [dts_pkg::CNT_W-1:0]   trow_ff, trow_in;
   logic [dts_pkg::POS_W-1:0]   cit_ff, cit_in;
   logic [dts_pkg::POS_W-1:0]   rit_ff, rit_in;
   logic [dts_pkg::DIM_W-1:0]   tw_ff, tw_in;
   logic [dts_pkg::DIM_W-1:0]   th_ff, th_in;
   logic                        active_ff, active_in;
   logic                        found_ff, found_in;
   logic                        seek_end_ff, seek_end_in;
   logic [dts_pkg::PIX_W-1:0]   pix_ff, pix_in;
   logic [dts_pkg::COORD_W-1:0] y_ff, y_in;
   logic [dts_pkg::COORD_W-1:0] x_ff, x_in;
   logic                        last_ff, last_in;
   logic                        drop_ff, drop_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   dts_pkg::dts_rsp_type        rsp_ff, rsp_in;

   logic                           div_go;
   logic [dts_pkg::DIM_W-1:0]      div_dividend;
   logic [dts_pkg::CNT_W-1:0]      div_divisor;
   logic                           div_done;
   logic [dts_pkg::DIM_W-1:0]      div_q;

   logic                           ram_we;
   logic                           ram_re;
   logic [dts_pkg::MAP_WORD_W-1:0] ram_rdata;

   logic                        out_free;
   logic                        seek_fail;
   logic                        col_wrap;
   logic [SUM_W-1:0]            tile_sum;
   logic                        tile_hit;
   logic                        do_xy;
   logic                        fast_pix;
   logic [dts_pkg::DIM_W-1:0]   cit_inc;
   logic [dts_pkg::DIM_W-1:0]   rit_inc;
   logic                        col_end;
   logic                        row_end;
   dts_pkg::dts_back_state_type xy_next;
   logic [PROD_W-1:0]           addr_full;

   dts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (div_go),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_q)
   );

   dts_ram #(
      .WIDTH (dts_pkg::MAP_WORD_W),
      .DEPTH (dts_pkg::MAP_WORDS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (dts_pkg::MAP_AW'(head.index)),
      .wr_data (head.data),
      .rd_en   (ram_re),
      .rd_addr (dts_pkg::MAP_AW'(tile_sum >> dts_pkg::MAP_BIT_W)),
      .rd_data (ram_rdata)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign seek_fail = tw_ff == '0 || th_ff == '0 || trow_ff >= cfg.down;
   assign col_wrap  = tcol_ff >= cfg.across;
   assign tile_sum  = SUM_W'(trow_ff[dts_pkg::ROWCOL_W-1:0]) * SUM_W'(cfg.across)
                    + SUM_W'(tcol_ff[dts_pkg::ROWCOL_W-1:0]);
   assign tile_hit  = (32'(tile_sum) < dts_pkg::MAX_TILES)
                    && ram_rdata[tile_sum[dts_pkg::MAP_BIT_W-1:0]];
   assign ram_re    = state_ff == dts_pkg::B_SEEK;

   assign fast_pix  = state_ff == dts_pkg::B_IDLE && head_valid
                    && head.op == dts_pkg::OP_PIXEL && active_ff && found_ff;
   assign do_xy     = fast_pix || state_ff == dts_pkg::B_XY;
   assign cit_inc   = dts_pkg::DIM_W'(cit_ff) + 1'b1;
   assign rit_inc   = dts_pkg::DIM_W'(rit_ff) + 1'b1;
   assign col_end   = cit_inc >= tw_ff;
   assign row_end   = rit_inc >= th_ff;
   assign xy_next   = (col_end && row_end) ? dts_pkg::B_SEEK : dts_pkg::B_EMIT;
   assign addr_full = PROD_W'(y_ff) * PROD_W'(cfg.fw) + PROD_W'(x_ff);

   assign div_dividend = (state_ff == dts_pkg::B_DIV_W) ? cfg.fh : cfg.fw;
   assign div_divisor  = (state_ff == dts_pkg::B_DIV_W) ? cfg.down : cfg.across;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dts_pkg::B_IDLE: begin
            if (head_valid) begin
               unique case (head.op)
                  dts_pkg::OP_START: state_in = dts_pkg::B_DIV_W;
                  dts_pkg::OP_MAP:   state_in = dts_pkg::B_IDLE;
                  dts_pkg::OP_PIXEL: begin
                     if (!active_ff) begin
                        state_in = dts_pkg::B_EMIT;
                     end else if (found_ff) begin
                        state_in = xy_next;
                     end else begin
                        state_in = dts_pkg::B_SEEK;
                     end
                  end
                  default: state_in = dts_pkg::B_IDLE;
               endcase
            end
         end
         dts_pkg::B_DIV_W: begin
            if (div_done) begin
               state_in = dts_pkg::B_DIV_H;
            end
         end
         dts_pkg::B_DIV_H: begin
            if (div_done) begin
               state_in = dts_pkg::B_IDLE;
            end
         end
         dts_pkg::B_SEEK: begin
            priority if (seek_fail) begin
               state_in = dts_pkg::B_EMIT;
            end else if (col_wrap) begin
               state_in = dts_pkg::B_SEEK;
            end else begin
               state_in = dts_pkg::B_TEST;
            end
         end
         dts_pkg::B_TEST: begin
            if (!tile_hit) begin
               state_in = dts_pkg::B_SEEK;
            end else if (seek_end_ff) begin
               state_in = dts_pkg::B_EMIT;
            end else begin
               state_in = dts_pkg::B_XY;
            end
         end
         dts_pkg::B_XY: state_in = xy_next;
         dts_pkg::B_EMIT: begin
            if (out_free) begin
               state_in = dts_pkg::B_IDLE;
            end
         end
         default: state_in = dts_pkg::B_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      tcol_in     = tcol_ff;
      trow_in     = trow_ff;
      cit_in      = cit_ff;
      rit_in      = rit_ff;
      tw_in       = tw_ff;
      th_in       = th_ff;
      active_in   = active_ff;
      found_in    = found_ff;
      seek_end_in = seek_end_ff;
      pix_in      = pix_ff;
      y_in        = y_ff;
      x_in        = x_ff;
      last_in     = last_ff;
      drop_in     = drop_ff;
      head_pop    = 1'b0;
      ram_we      = 1'b0;
      div_go      = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;

      unique case (state_ff)
         dts_pkg::B_IDLE: begin
            if (head_valid) begin
               head_pop = 1'b1;
               unique case (head.op)
                  dts_pkg::OP_START: begin
                     div_go    = 1'b1;
                     tcol_in   = '0;
                     trow_in   = '0;
                     cit_in    = '0;
                     rit_in    = '0;
                     found_in  = 1'b0;
                     active_in = 1'b1;
                  end
                  dts_pkg::OP_MAP: begin
                     ram_we   = 1'b1;
                     found_in = 1'b0;
                  end
                  dts_pkg::OP_PIXEL: begin
                     pix_in      = head.data[dts_pkg::PIX_W-1:0];
                     seek_end_in = 1'b0;
                     if (!active_ff) begin
                        y_in    = '0;
                        x_in    = '0;
                        last_in = 1'b0;
                        drop_in = 1'b1;
                     end
                  end
                  default: head_pop = 1'b1;
               endcase
            end
         end
         dts_pkg::B_DIV_W: begin
            if (div_done) begin
               tw_in  = div_q;
               div_go = 1'b1;
            end
         end
         dts_pkg::B_DIV_H: begin
            if (div_done) begin
               th_in = div_q;
            end
         end
         dts_pkg::B_SEEK: begin
            priority if (seek_fail) begin
               active_in = 1'b0;
               if (seek_end_ff) begin
                  last_in = 1'b1;
                  drop_in = 1'b0;
               end else begin
                  y_in    = '0;
                  x_in    = '0;
                  last_in = 1'b0;
                  drop_in = 1'b1;
               end
            end else if (col_wrap) begin
               tcol_in = '0;
               trow_in = trow_ff + 1'b1;
            end else begin
               tcol_in = tcol_ff;
            end
         end
         dts_pkg::B_TEST: begin
            if (tile_hit) begin
               found_in = 1'b1;
               last_in  = 1'b0;
               drop_in  = 1'b0;
            end else begin
               tcol_in = tcol_ff + 1'b1;
            end
         end
         dts_pkg::B_XY: begin
            seek_end_in = seek_end_ff;
         end
         dts_pkg::B_EMIT: begin
            if (out_free) begin
               rsp_valid_in      = 1'b1;
               rsp_in.address    = addr_full[dts_pkg::ADDR_W-1:0];
               rsp_in.pixel_out  = pix_ff;
               rsp_in.last       = last_ff;
               rsp_in.dropped    = drop_ff;
            end
         end
         default: head_pop = 1'b0;
      endcase

      // place the pixel and step the position inside the tile
      if (do_xy) begin
         y_in = dts_pkg::COORD_W'(trow_ff[dts_pkg::ROWCOL_W-1:0]) * dts_pkg::COORD_W'(th_ff)
              + dts_pkg::COORD_W'(rit_ff);
         x_in = dts_pkg::COORD_W'(tcol_ff[dts_pkg::ROWCOL_W-1:0]) * dts_pkg::COORD_W'(tw_ff)
              + dts_pkg::COORD_W'(cit_ff);
         last_in = 1'b0;
         drop_in = 1'b0;
         if (col_end) begin
            cit_in = '0;
            if (row_end) begin
               rit_in      = '0;
               tcol_in     = tcol_ff + 1'b1;
               found_in    = 1'b0;
               seek_end_in = 1'b1;
            end else begin
               rit_in = dts_pkg::POS_W'(rit_inc);
            end
         end else begin
            cit_in = dts_pkg::POS_W'(cit_inc);
         end
      end

      // a new tile count moves every tile index
      if (cfg_wr) begin
         found_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dts_pkg::B_IDLE;
         tcol_ff      <= '0;
         trow_ff      <= '0;
         cit_ff       <= '0;
         rit_ff       <= '0;
         tw_ff        <= '0;
         th_ff        <= '0;
         active_ff    <= 1'b0;
         found_ff     <= 1'b0;
         seek_end_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tcol_ff      <= tcol_in;
         trow_ff      <= trow_in;
         cit_ff       <= cit_in;
         rit_ff       <= rit_in;
         tw_ff        <= tw_in;
         th_ff        <= th_in;
         active_ff    <= active_in;
         found_ff     <= found_in;
         seek_end_ff  <= seek_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pix_ff  <= pix_in;
      y_ff    <= y_in;
      x_ff    <= x_in;
      last_ff <= last_in;
      drop_ff <= drop_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
